### src/msza_pkg.sv
package msza_pkg;

   // Configuration port
   localparam int AddrW    = 5;
   localparam int DataW    = 32;
   localparam int RegIdxW  = AddrW - 2;

   localparam logic [RegIdxW-1:0] RegInSamples   = 3'd0;
   localparam logic [RegIdxW-1:0] RegZoom        = 3'd1;
   localparam logic [RegIdxW-1:0] RegMode        = 3'd2;
   localparam logic [RegIdxW-1:0] RegBandCount   = 3'd3;
   localparam logic [RegIdxW-1:0] RegMaskEnabled = 3'd4;

   // Register field widths
   localparam int SampCfgW = 13;
   localparam int ModeW    = 2;
   localparam int BandW    = 3;

   localparam logic [ModeW-1:0] ModeSum = 2'd0;
   localparam logic [ModeW-1:0] ModeMin = 2'd1;
   localparam logic [ModeW-1:0] ModeMax = 2'd2;

   localparam logic CmdAccum = 1'b0;
   localparam logic CmdClear = 1'b1;

   // Item fields
   localparam int SampleW   = 32;
   localparam int AccW      = 48;
   localparam int CountW    = 16;
   localparam int BinOutW   = 12;
   localparam int OutLanes  = 4;
   localparam int OutLaneW  = 2;

   localparam logic [CountW-1:0] CountMax = 16'hFFFF;
   localparam logic [AccW-1:0]   AccMax   = 48'h7FFF_FFFF_FFFF;
   localparam logic [AccW-1:0]   AccMin   = 48'h8000_0000_0000;

   typedef struct packed {
      logic [SampCfgW-1:0] in_samples;
      logic [SampCfgW-1:0] zoom;
      logic [ModeW-1:0]    mode;
      logic [BandW-1:0]    band_count;
      logic                mask_enabled;
   } cfg_type;

   typedef struct packed {
      logic last;
      logic fresh;
   } seq_type;

   typedef struct packed {
      logic                              mask_ok;
      logic                              last;
      logic                              fresh;
      logic [OutLanes-1:0][SampleW-1:0]  values;
   } item_type;

endpackage

### src/msza_chan_if.sv
interface msza_req_if;
   logic               valid;
   logic               ready;
   logic               cmd;
   logic               mask_ok;
   logic signed [31:0] value_0;
   logic signed [31:0] value_1;
   logic signed [31:0] value_2;
   logic signed [31:0] value_3;

   modport source (output valid, cmd, mask_ok, value_0, value_1, value_2, value_3,
                   input ready);
   modport sink   (input valid, cmd, mask_ok, value_0, value_1, value_2, value_3,
                   output ready);
endinterface

interface msza_rsp_if;
   logic               valid;
   logic               ready;
   logic [11:0]        bin_index;
   logic [15:0]        pixel_count;
   logic signed [47:0] acc_0;
   logic signed [47:0] acc_1;
   logic signed [47:0] acc_2;
   logic signed [47:0] acc_3;
   logic               line_end;

   modport source (output valid, bin_index, pixel_count, acc_0, acc_1, acc_2, acc_3,
                   line_end, input ready);
   modport sink   (input valid, bin_index, pixel_count, acc_0, acc_1, acc_2, acc_3,
                   line_end, output ready);
endinterface

### src/msza_csr.sv
module msza_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [msza_pkg::AddrW-1:0] paddr,
   input  logic [msza_pkg::DataW-1:0] pwdata,
   output logic [msza_pkg::DataW-1:0] prdata,
   output logic                       pready,
   output msza_pkg::cfg_type          cfg
);
   import msza_pkg::*;

   cfg_type              cfg_ff;
   cfg_type              cfg_in;
   logic [RegIdxW-1:0]   reg_idx;
   logic                 wr_en;

   assign reg_idx = paddr[AddrW-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            RegInSamples:   cfg_in.in_samples   = pwdata[SampCfgW-1:0];
            RegZoom:        cfg_in.zoom         = pwdata[SampCfgW-1:0];
            RegMode:        cfg_in.mode         = pwdata[ModeW-1:0];
            RegBandCount:   cfg_in.band_count   = pwdata[BandW-1:0];
            RegMaskEnabled: cfg_in.mask_enabled = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         RegInSamples:   prdata = DataW'(cfg_ff.in_samples);
         RegZoom:        prdata = DataW'(cfg_ff.zoom);
         RegMode:        prdata = DataW'(cfg_ff.mode);
         RegBandCount:   prdata = DataW'(cfg_ff.band_count);
         RegMaskEnabled: prdata = DataW'(cfg_ff.mask_enabled);
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.in_samples   <= SampCfgW'(4096);
         cfg_ff.zoom         <= SampCfgW'(2);
         cfg_ff.mode         <= ModeSum;
         cfg_ff.band_count   <= BandW'(1);
         cfg_ff.mask_enabled <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### src/msza_seq.sv
module msza_seq #(
   parameter int MAX_SAMPLES = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   take,
   input  logic                   clear,
   input  msza_pkg::cfg_type      cfg,
   output logic [((MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1)-1:0] bin,
   output msza_pkg::seq_type      info
);
   import msza_pkg::*;

   localparam int PosW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int SeenW = PosW + 1;
   localparam int CmpW  = (SeenW > SampCfgW) ? SeenW : SampCfgW;

   logic [PosW-1:0]  pos_ff, pos_in, bin_ff, bin_in, fill_ff, fill_in;
   logic [SeenW-1:0] seen_ff, seen_in;
   logic [PosW-1:0]  pos_cur, bin_cur, fill_cur;
   logic [CmpW-1:0]  n_lim, z_lim, pos_next, fill_next;
   logic             wrap;

   always_comb begin
      if (cfg.in_samples == '0) begin
         n_lim = CmpW'(1);
      end else if (CmpW'(cfg.in_samples) > CmpW'(MAX_SAMPLES)) begin
         n_lim = CmpW'(MAX_SAMPLES);
      end else begin
         n_lim = CmpW'(cfg.in_samples);
      end
      z_lim = (cfg.zoom == '0) ? CmpW'(1) : CmpW'(cfg.zoom);

      // A shorter line length written while idle restarts the line.
      wrap      = CmpW'(pos_ff) >= n_lim;
      pos_cur   = wrap ? '0 : pos_ff;
      bin_cur   = wrap ? '0 : bin_ff;
      fill_cur  = wrap ? '0 : fill_ff;
      pos_next  = CmpW'(pos_cur) + CmpW'(1);
      fill_next = CmpW'(fill_cur) + CmpW'(1);

      info.last  = pos_next >= n_lim;
      // Bins are visited in order from zero, so every bin at or above the
      // visited count is empty since the last clear.
      info.fresh = SeenW'(bin_cur) >= seen_ff;
      bin        = bin_cur;

      pos_in  = pos_ff;
      bin_in  = bin_ff;
      fill_in = fill_ff;
      seen_in = seen_ff;
      if (clear) begin
         pos_in  = '0;
         bin_in  = '0;
         fill_in = '0;
         seen_in = '0;
      end else if (take) begin
         if (info.fresh) begin
            seen_in = SeenW'(bin_cur) + SeenW'(1);
         end
         if (info.last) begin
            pos_in  = '0;
            bin_in  = '0;
            fill_in = '0;
         end else begin
            pos_in = pos_next[PosW-1:0];
            if (fill_next >= z_lim) begin
               fill_in = '0;
               bin_in  = bin_cur + PosW'(1);
            end else begin
               fill_in = fill_next[PosW-1:0];
               bin_in  = bin_cur;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         bin_ff  <= '0;
         fill_ff <= '0;
         seen_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         bin_ff  <= bin_in;
         fill_ff <= fill_in;
         seen_ff <= seen_in;
      end
   end

endmodule

### src/msza_ram.sv
module msza_ram #(
   parameter int Depth = 4096,
   parameter int Width = 208
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] bin_mem [Depth];
   logic [Width-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bin_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= bin_mem[rd_addr];
      end
   end

endmodule

### src/msza_update.sv
module msza_update #(
   parameter int LANES = 4
) (
   input  msza_pkg::cfg_type                                 cfg,
   input  msza_pkg::item_type                                item,
   input  logic [msza_pkg::CountW-1:0]                       old_count,
   input  logic [LANES-1:0][msza_pkg::AccW-1:0]              old_acc,
   output logic [msza_pkg::CountW-1:0]                       new_count,
   output logic [LANES-1:0][msza_pkg::AccW-1:0]              new_acc,
   output logic [msza_pkg::OutLanes-1:0][msza_pkg::AccW-1:0] out_acc
);
   import msza_pkg::*;

   localparam int NbMax = (LANES < OutLanes) ? LANES : OutLanes;

   logic [BandW-1:0] nb;
   logic             pix_ok;
   logic             was_empty;

   function automatic logic [AccW-1:0] sext_sample(input logic [SampleW-1:0] s);
      return {{(AccW - SampleW){s[SampleW-1]}}, s};
   endfunction

   function automatic logic [AccW-1:0] lane_next(
      input logic [AccW-1:0]  old_v,
      input logic [AccW-1:0]  smp,
      input logic [ModeW-1:0] mode,
      input logic             empty
   );
      logic [AccW:0]   sum;
      logic [AccW-1:0] res;
      sum = {old_v[AccW-1], old_v} + {smp[AccW-1], smp};
      res = old_v;
      if (empty) begin
         res = smp;
      end else begin
         case (mode)
            ModeSum: begin
               if (sum[AccW] != sum[AccW-1]) begin
                  res = sum[AccW] ? AccMin : AccMax;
               end else begin
                  res = sum[AccW-1:0];
               end
            end
            ModeMin: if ($signed(smp) < $signed(old_v)) res = smp;
            ModeMax: if ($signed(smp) > $signed(old_v)) res = smp;
            default: res = old_v;
         endcase
      end
      return res;
   endfunction

   assign nb        = (cfg.band_count > BandW'(NbMax)) ? BandW'(NbMax) : cfg.band_count;
   assign pix_ok    = !cfg.mask_enabled || item.mask_ok;
   assign was_empty = old_count == '0;

   always_comb begin
      if (!pix_ok) begin
         new_count = old_count;
      end else if (was_empty) begin
         new_count = CountW'(1);
      end else if (old_count == CountMax) begin
         new_count = old_count;
      end else begin
         new_count = old_count + CountW'(1);
      end
   end

   always_comb begin
      for (int b = 0; b < LANES; b++) begin
         if (pix_ok && (b < int'(nb))) begin
            new_acc[b] = lane_next(old_acc[b], sext_sample(item.values[b[OutLaneW-1:0]]),
                                   cfg.mode, was_empty);
         end else begin
            new_acc[b] = old_acc[b];
         end
      end
   end

   // Bands outside the ones in use, and empty bins, report zero.
   always_comb begin
      for (int b = 0; b < OutLanes; b++) begin
         if ((new_count != '0) && (b < int'(nb))) begin
            out_acc[b] = new_acc[b % LANES];
         end else begin
            out_acc[b] = '0;
         end
      end
   end

endmodule

### src/masked_sample_zoom_accumulator.sv
// Masked block down-sampler. Each item on req_ch is either a pixel (up to four
// bands of signed 16.16 samples plus a mask flag) or a clear command. A pixel is
// folded into output bin position/zoom of its line, and one item comes back on
// rsp_ch per pixel with the bin index, the bin's valid-pixel count and the
// per-band saturating sum, minimum or maximum. A clear item returns nothing.
// Registers are written through the APB-style port; the user must write them
// only while the block is idle, as the block itself does not enforce it. The
// block takes one item every cycle while rsp_ch does not stall: each pixel
// needs one read-modify-write of its bin row, the read issued at the accepting
// edge and the write as the pixel leaves the input stage, with the last write
// forwarded so that back-to-back pixels of one bin chain. When rsp_ch stalls,
// the result register holds its item and one more pixel waits in the input
// stage; req_ch.ready then drops until the result is taken.
// Reset (synchronous, active high) restores the register defaults and empties
// all bins at once: a visited-bin count marks which rows of the bin memory
// hold data since the last clear, so no clearing pass is needed.
module masked_sample_zoom_accumulator #(
   parameter int MAX_SAMPLES = 4096,
   parameter int LANES       = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   msza_req_if.sink                   req_ch,
   msza_rsp_if.source                 rsp_ch,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [msza_pkg::AddrW-1:0] paddr,
   input  logic [msza_pkg::DataW-1:0] pwdata,
   output logic [msza_pkg::DataW-1:0] prdata,
   output logic                       pready
);
   import msza_pkg::*;

   localparam int PosW    = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int AccRowW = LANES * AccW;
   localparam int RowW    = CountW + AccRowW;

   cfg_type                      cfg;
   seq_type                      seq_info;
   logic [PosW-1:0]              seq_bin;
   logic                         acc_take;
   logic                         clr_take;
   logic                         s1_adv;

   // Input stage: the accepted pixel, with its bin row read alongside.
   logic                         s1_valid_ff, s1_valid_in;
   item_type                     s1_item_ff;
   logic [PosW-1:0]              s1_bin_ff;
   logic [RowW-1:0]              rd_row;
   logic [RowW-1:0]              wr_row;

   // Last row written, for a pixel whose read raced that write.
   logic                         fwd_valid_ff, fwd_valid_in;
   logic [PosW-1:0]              fwd_bin_ff;
   logic [RowW-1:0]              fwd_row_ff;
   logic [RowW-1:0]              old_row;

   logic [CountW-1:0]            old_count, new_count;
   logic [LANES-1:0][AccW-1:0]   old_acc, new_acc;
   logic [OutLanes-1:0][AccW-1:0] out_acc;

   // Result register.
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [BinOutW-1:0]           rsp_bin_ff;
   logic [CountW-1:0]            rsp_count_ff;
   logic [OutLanes-1:0][AccW-1:0] rsp_acc_ff;
   logic                         rsp_last_ff;

   msza_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // The input stage moves on whenever the result register is free or is
   // being emptied in this cycle.
   assign s1_adv       = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_adv;
   assign acc_take     = req_ch.valid && req_ch.ready && (req_ch.cmd == CmdAccum);
   assign clr_take     = req_ch.valid && req_ch.ready && (req_ch.cmd == CmdClear);

   msza_seq #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_seq (
      .clock (clock),
      .reset (reset),
      .take  (acc_take),
      .clear (clr_take),
      .cfg   (cfg),
      .bin   (seq_bin),
      .info  (seq_info)
   );

   msza_ram #(
      .Depth (MAX_SAMPLES),
      .Width (RowW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_bin_ff),
      .wr_data (wr_row),
      .rd_en   (acc_take),
      .rd_addr (seq_bin),
      .rd_data (rd_row)
   );

   // The memory read at the accepting edge misses a write to the same bin
   // made at that same edge; the forward register always holds the newest
   // row of its bin, so it wins whenever the bins match.
   assign old_row   = (fwd_valid_ff && (fwd_bin_ff == s1_bin_ff)) ? fwd_row_ff : rd_row;
   assign old_count = s1_item_ff.fresh ? '0 : old_row[RowW-1 -: CountW];
   assign old_acc   = old_row[AccRowW-1:0];
   assign wr_row    = {new_count, new_acc};

   msza_update #(
      .LANES (LANES)
   ) u_update (
      .cfg       (cfg),
      .item      (s1_item_ff),
      .old_count (old_count),
      .old_acc   (old_acc),
      .new_count (new_count),
      .new_acc   (new_acc),
      .out_acc   (out_acc)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_ch.ready) begin
         s1_valid_in = acc_take;
      end
      fwd_valid_in = fwd_valid_ff || s1_adv;
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc_take) begin
         s1_bin_ff            <= seq_bin;
         s1_item_ff.mask_ok   <= req_ch.mask_ok;
         s1_item_ff.last      <= seq_info.last;
         s1_item_ff.fresh     <= seq_info.fresh;
         s1_item_ff.values[0] <= req_ch.value_0;
         s1_item_ff.values[1] <= req_ch.value_1;
         s1_item_ff.values[2] <= req_ch.value_2;
         s1_item_ff.values[3] <= req_ch.value_3;
      end
      if (s1_adv) begin
         fwd_bin_ff   <= s1_bin_ff;
         fwd_row_ff   <= wr_row;
         rsp_bin_ff   <= BinOutW'(s1_bin_ff);
         rsp_count_ff <= new_count;
         rsp_acc_ff   <= out_acc;
         rsp_last_ff  <= s1_item_ff.last;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.bin_index   = rsp_bin_ff;
   assign rsp_ch.pixel_count = rsp_count_ff;
   assign rsp_ch.acc_0       = $signed(rsp_acc_ff[0]);
   assign rsp_ch.acc_1       = $signed(rsp_acc_ff[1]);
   assign rsp_ch.acc_2       = $signed(rsp_acc_ff[2]);
   assign rsp_ch.acc_3       = $signed(rsp_acc_ff[3]);
   assign rsp_ch.line_end    = rsp_last_ff;

   // Back pressure only comes from a full pipeline behind a stalled receiver.
   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> s1_valid_ff && rsp_valid_ff && !rsp_ch.ready)
      else $error("input stalled while the pipeline had room");

   // A new result only appears from a pixel held in the input stage.
   a_rsp_from_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("result raised without a pixel in the input stage");

   // The bin count never goes down while a pixel is folded in.
   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      s1_adv |-> new_count >= old_count)
      else $error("bin count decreased on update");

   // Each row write is captured for forwarding on the next cycle.
   a_fwd_tracks_write: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> fwd_valid_ff && (fwd_bin_ff == $past(s1_bin_ff)))
      else $error("forward register lost the last bin write");

endmodule
